@@ src/sfb_pkg.sv @@
// Package for the seam feather blend: field widths, register indexes and the
// packed transfer types shared by the top level and the divider pipeline.
// Depends on nothing.
`default_nettype none

package sfb_pkg;

    localparam int CH          = 3;
    localparam int PIX_W       = 8;
    localparam int COL_W       = 12;
    localparam int WID_W       = 13;
    localparam int NUM_W       = PIX_W + WID_W;
    localparam int Q_W         = PIX_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = WID_W;

    localparam int DEFAULT_MAX_WIDTH = 4096;

    localparam logic [COL_W-1:0] OVERLAP_START_RESET = '0;
    localparam logic [WID_W-1:0] IMAGE_WIDTH_RESET   = WID_W'(4096);

    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] first_c0;
        logic [PIX_W-1:0] first_c1;
        logic [PIX_W-1:0] first_c2;
        logic [PIX_W-1:0] second_c0;
        logic [PIX_W-1:0] second_c1;
        logic [PIX_W-1:0] second_c2;
    } sfb_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_c0;
        logic [PIX_W-1:0] out_c1;
        logic [PIX_W-1:0] out_c2;
        logic             in_overlap;
    } sfb_result_t;

    // Sideband that rides along with the numerators through the divider.
    typedef struct packed {
        logic [CH-1:0][PIX_W-1:0] first;
        logic [CH-1:0][PIX_W-1:0] second;
        logic                     in_overlap;
        logic                     blend;
        logic                     use_second;
    } sfb_side_t;

endpackage

`default_nettype wire

@@ src/sfb_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage for three channels
// sharing one divisor, with a valid bit and a sideband struct carried along.
// Depends on sfb_pkg.
`default_nettype none

module sfb_div_pipe
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic [sfb_pkg::CH-1:0][sfb_pkg::NUM_W-1:0] in_num,
    input  wire logic [sfb_pkg::WID_W-1:0]              in_den,
    input  wire sfb_pkg::sfb_side_t                     in_side,
    output logic                                        out_valid,
    output logic [sfb_pkg::CH-1:0][sfb_pkg::Q_W-1:0]    out_quo,
    output sfb_pkg::sfb_side_t                          out_side
);
    import sfb_pkg::*;

    logic                          stg_valid_reg [Q_W];
    logic [CH-1:0][NUM_W-1:0]      stg_rem_reg   [Q_W];
    logic [CH-1:0][Q_W-1:0]        stg_quo_reg   [Q_W];
    logic [WID_W-1:0]              stg_den_reg   [Q_W];
    sfb_side_t                     stg_side_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic                     src_valid;
        logic [CH-1:0][NUM_W-1:0] src_rem;
        logic [CH-1:0][Q_W-1:0]   src_quo;
        logic [WID_W-1:0]         src_den;
        sfb_side_t                src_side;
        logic [NUM_W-1:0]         shifted_den;
        logic [CH-1:0][NUM_W-1:0] rem_next;
        logic [CH-1:0][Q_W-1:0]   quo_next;

        if (k == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = in_num;
            assign src_quo   = '0;
            assign src_den   = in_den;
            assign src_side  = in_side;
        end
        else
        begin : g_rest
            assign src_valid = stg_valid_reg[k-1];
            assign src_rem   = stg_rem_reg[k-1];
            assign src_quo   = stg_quo_reg[k-1];
            assign src_den   = stg_den_reg[k-1];
            assign src_side  = stg_side_reg[k-1];
        end

        // Stage k settles quotient bit Q_W-1-k against the divisor shifted up.
        assign shifted_den = NUM_W'(src_den) << (Q_W - 1 - k);

        always_comb
        begin
            for (int c = 0; c < CH; c++)
            begin
                if (src_rem[c] >= shifted_den)
                begin
                    rem_next[c] = src_rem[c] - shifted_den;
                    quo_next[c] = {src_quo[c][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = src_rem[c];
                    quo_next[c] = {src_quo[c][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_valid_reg[k] <= 1'b0;
            end
            else
            begin
                stg_valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            stg_rem_reg[k]  <= rem_next;
            stg_quo_reg[k]  <= quo_next;
            stg_den_reg[k]  <= src_den;
            stg_side_reg[k] <= src_side;
        end
    end

    assign out_valid = stg_valid_reg[Q_W-1];
    assign out_quo   = stg_quo_reg[Q_W-1];
    assign out_side  = stg_side_reg[Q_W-1];

endmodule

`default_nettype wire

@@ src/seam_feather_blend.sv @@
// Top level of the seam feather blend: configuration registers, overlap
// test, weight products, numerator sum and the output register.
// Depends on sfb_pkg and sfb_div_pipe.
//
//  Channel   Ports                               Transfer
//  --------  ----------------------------------  -----------------------------
//  input     start, busy, item                   edge with start high, busy low
//  result    done, result                        edge ending the cycle of done
//  config    cfg_write, cfg_index, cfg_data      edge with cfg_write high
//
// One pixel is accepted every cycle; busy is always low. Each result passes
// through registers for the overlap test, the weight products and the
// numerator sum, the stages of the divider pipeline (one quotient bit per
// stage) and the output register. Reset clears the valid bits and sets the
// configuration registers to their reset values. The receiver cannot stall,
// so the pipeline never holds.
`default_nettype none

module seam_feather_blend
#(
    parameter int MAX_WIDTH = sfb_pkg::DEFAULT_MAX_WIDTH
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire sfb_pkg::sfb_item_t               item,
    output logic                                  done,
    output sfb_pkg::sfb_result_t                  result,
    input  wire logic                             cfg_write,
    input  wire logic [sfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sfb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sfb_pkg::*;

    localparam logic [WID_W+1:0] MaxWidthVal = (WID_W + 2)'(MAX_WIDTH);

    logic [COL_W-1:0]          overlap_start_reg;
    logic [WID_W-1:0]          image_width_reg;

    logic                      accept;
    logic [WID_W-1:0]          width_clamped;
    logic                      in_span;
    logic                      first_zero;
    logic                      second_zero;
    sfb_side_t                 side_next;

    // Stage 1: weights.
    logic                      s1_valid_reg;
    logic [WID_W-1:0]          s1_w_reg;
    logic [WID_W-1:0]          s1_d_reg;
    logic [WID_W-1:0]          s1_wmd_reg;
    sfb_side_t                 s1_side_reg;

    // Stage 2: products.
    logic                      s2_valid_reg;
    logic [CH-1:0][NUM_W-1:0]  s2_pa_reg;
    logic [CH-1:0][NUM_W-1:0]  s2_pb_reg;
    logic [WID_W-1:0]          s2_w_reg;
    sfb_side_t                 s2_side_reg;

    // Stage 3: numerators.
    logic                      s3_valid_reg;
    logic [CH-1:0][NUM_W-1:0]  s3_num_reg;
    logic [WID_W-1:0]          s3_w_reg;
    sfb_side_t                 s3_side_reg;

    logic                      div_valid;
    logic [CH-1:0][Q_W-1:0]    div_quo;
    sfb_side_t                 div_side;

    logic [CH-1:0][PIX_W-1:0]  pix_next;
    logic                      done_reg;
    sfb_result_t               result_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_start_reg <= OVERLAP_START_RESET;
            image_width_reg   <= IMAGE_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OVERLAP_START: overlap_start_reg <= cfg_data[COL_W-1:0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign width_clamped = ({2'b00, image_width_reg} > MaxWidthVal) ?
                           MaxWidthVal[WID_W-1:0] : image_width_reg;

    assign in_span = ({1'b0, item.column} >= {1'b0, overlap_start_reg}) &&
                     ({1'b0, item.column} < width_clamped);

    assign first_zero  = ~|{item.first_c0, item.first_c1, item.first_c2};
    assign second_zero = ~|{item.second_c0, item.second_c1, item.second_c2};

    always_comb
    begin
        side_next.first      = {item.first_c2, item.first_c1, item.first_c0};
        side_next.second     = {item.second_c2, item.second_c1, item.second_c0};
        side_next.in_overlap = in_span;
        side_next.blend      = in_span & ~second_zero & ~first_zero;
        side_next.use_second = in_span & ~second_zero & first_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= div_valid;
        end
    end

    // Outside the overlap the weights are meaningless; the sideband then
    // selects the first pixel, so the quotient is never used.
    always_ff @(posedge clk)
    begin
        s1_w_reg    <= width_clamped - {1'b0, overlap_start_reg};
        s1_d_reg    <= {1'b0, item.column} - {1'b0, overlap_start_reg};
        s1_wmd_reg  <= width_clamped - {1'b0, item.column};
        s1_side_reg <= side_next;

        for (int c = 0; c < CH; c++)
        begin
            s2_pa_reg[c] <= NUM_W'(s1_side_reg.first[c]) * NUM_W'(s1_wmd_reg);
            s2_pb_reg[c] <= NUM_W'(s1_side_reg.second[c]) * NUM_W'(s1_d_reg);
        end
        s2_w_reg    <= s1_w_reg;
        s2_side_reg <= s1_side_reg;

        for (int c = 0; c < CH; c++)
        begin
            s3_num_reg[c] <= s2_pa_reg[c] + s2_pb_reg[c];
        end
        s3_w_reg    <= s2_w_reg;
        s3_side_reg <= s2_side_reg;
    end

    sfb_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_num    (s3_num_reg),
        .in_den    (s3_w_reg),
        .in_side   (s3_side_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            if (div_side.blend)
            begin
                pix_next[c] = div_quo[c];
            end
            else if (div_side.use_second)
            begin
                pix_next[c] = div_side.second[c];
            end
            else
            begin
                pix_next[c] = div_side.first[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.out_c0     <= pix_next[0];
        result_reg.out_c1     <= pix_next[1];
        result_reg.out_c2     <= pix_next[2];
        result_reg.in_overlap <= div_side.in_overlap;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
